@@ sv/aesgcm_pkg.sv @@
// Shared types, constants and AES helper functions for the AES-128-GCM engine.
// Used by aesgcm_aes, aesgcm_ghash and aes128_gcm_engine_core; no dependencies.
package aesgcm_pkg;

    localparam int unsigned KEY_ROWS = 11;
    localparam int unsigned ROW_BITS = 4;
    localparam int unsigned CFG_IDX_BITS = 3;

    localparam logic [1:0] OP_AAD = 2'd0;
    localparam logic [1:0] OP_PAYLOAD = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_HIGH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_LOW = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONCE_HIGH = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NONCE_LOW = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DECRYPT_MODE = 3'd4;

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [7:0] GHASH_POLY = 8'he1;
    localparam logic [7:0] RCON_FIRST = 8'h01;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] data_high;
        logic [63:0] data_low;
        logic [4:0]  valid_bytes;
    } t_gcm_in;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
        logic [4:0]  out_bytes;
        logic        is_tag;
        logic        tag_match;
    } t_gcm_out;

    typedef struct packed {
        logic kexp;
        logic enc;
    } t_aes_req;

    typedef struct packed {
        logic start;
        logic load_h;
        logic clear;
    } t_gh_ctl;

    typedef enum logic [1:0] {
        AES_IDLE,
        AES_KEXP,
        AES_ENC
    } t_aes_state;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEXP,
        ST_HENC,
        ST_DISPATCH,
        ST_AAD_HASH,
        ST_PAY_ENC,
        ST_PAY_HASH,
        ST_FIN_HASH,
        ST_FIN_ENC,
        ST_EMIT
    } t_ctl_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input logic [127:0] s, input int unsigned i);
        get_byte = s[127 - 8*i -: 8];
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[i + 4*c] = SBOX[get_byte(s, i + 4*((c + i) % 4))];
            end
        end
        if (!last) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c];
                a1 = t[4*c + 1];
                a2 = t[4*c + 2];
                a3 = t[4*c + 3];
                t[4*c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                t[4*c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                t[4*c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                t[4*c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127 - 8*i -: 8] = t[i];
        end
        aes_round = r;
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] rk,
                                                    input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w0, w1, w2, w3;
        t = {SBOX[rk[23:16]] ^ rc, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        w0 = rk[127:96] ^ t;
        w1 = rk[95:64] ^ w0;
        w2 = rk[63:32] ^ w1;
        w3 = rk[31:0] ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

endpackage

@@ sv/aesgcm_aes.sv @@
// AES-128 unit: key expansion into a round key memory and one round per cycle.
// Depends on aesgcm_pkg.
module aesgcm_aes (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aesgcm_pkg::t_aes_req  i_req,
    input  logic [127:0]          i_key,
    input  logic [127:0]          i_block,
    output logic                  o_done,
    output logic [127:0]          o_result
);

    logic [127:0] r_mem [aesgcm_pkg::KEY_ROWS];
    logic [127:0] r_rk_q;

    aesgcm_pkg::t_aes_state r_state, n_state;
    logic [aesgcm_pkg::ROW_BITS-1:0] r_cnt, n_cnt;
    logic [127:0] r_rk, n_rk;
    logic [7:0]   r_rcon, n_rcon;
    logic [127:0] r_s, n_s;
    logic         r_done, n_done;
    logic [aesgcm_pkg::ROW_BITS-1:0] rd_addr;

    localparam logic [aesgcm_pkg::ROW_BITS-1:0] LAST_ROW =
        aesgcm_pkg::ROW_BITS'(aesgcm_pkg::KEY_ROWS - 1);
    localparam logic [aesgcm_pkg::ROW_BITS-1:0] ENC_END =
        aesgcm_pkg::ROW_BITS'(aesgcm_pkg::KEY_ROWS);

    assign rd_addr = (r_cnt > LAST_ROW) ? LAST_ROW : r_cnt;

    always_ff @(posedge i_clk) begin
        if (r_state == aesgcm_pkg::AES_KEXP) begin
            r_mem[r_cnt] <= r_rk;
        end
        r_rk_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aesgcm_pkg::AES_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_rk   <= n_rk;
        r_rcon <= n_rcon;
        r_s    <= n_s;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rk    = r_rk;
        n_rcon  = r_rcon;
        n_s     = r_s;
        n_done  = 1'b0;
        unique case (r_state)
            aesgcm_pkg::AES_IDLE: begin
                n_cnt = '0;
                if (i_req.kexp) begin
                    n_rk    = i_key;
                    n_rcon  = aesgcm_pkg::RCON_FIRST;
                    n_state = aesgcm_pkg::AES_KEXP;
                end else if (i_req.enc) begin
                    n_s     = i_block;
                    n_state = aesgcm_pkg::AES_ENC;
                end
            end
            aesgcm_pkg::AES_KEXP: begin
                n_rk   = aesgcm_pkg::next_round_key(r_rk, r_rcon);
                n_rcon = aesgcm_pkg::xtime(r_rcon);
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_ROW) begin
                    n_done  = 1'b1;
                    n_state = aesgcm_pkg::AES_IDLE;
                end
            end
            aesgcm_pkg::AES_ENC: begin
                if (r_cnt == 1) begin
                    n_s = r_s ^ r_rk_q;
                end else if (r_cnt != 0) begin
                    n_s = aesgcm_pkg::aes_round(r_s, r_cnt == ENC_END) ^ r_rk_q;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == ENC_END) begin
                    n_done  = 1'b1;
                    n_state = aesgcm_pkg::AES_IDLE;
                end
            end
            default: begin
                n_state = aesgcm_pkg::AES_IDLE;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_s;

endmodule

@@ sv/aesgcm_ghash.sv @@
// GHASH accumulator with an 8-bit digit-serial multiplier by the hash subkey.
// Depends on aesgcm_pkg.
module aesgcm_ghash (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aesgcm_pkg::t_gh_ctl  i_ctl,
    input  logic [127:0]         i_data,
    output logic                 o_done,
    output logic [127:0]         o_acc
);

    logic [127:0] r_h;
    logic [127:0] r_acc;
    logic [127:0] r_x, r_z, r_v;
    logic [3:0]   r_cnt;
    logic         r_busy;
    logic         r_done;
    logic [127:0] step_z, step_v;

    always_comb begin
        logic lsb;
        step_z = r_z;
        step_v = r_v;
        for (int j = 0; j < 8; j++) begin
            if (r_x[127 - j]) begin
                step_z = step_z ^ step_v;
            end
            lsb = step_v[0];
            step_v = step_v >> 1;
            if (lsb) begin
                step_v[127:120] = step_v[127:120] ^ aesgcm_pkg::GHASH_POLY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_acc  <= step_z;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_h) begin
            r_h <= i_data;
        end
        if (i_ctl.start) begin
            r_x <= r_acc ^ i_data;
            r_z <= '0;
            r_v <= r_h;
        end else if (r_busy) begin
            r_x <= {r_x[119:0], 8'h00};
            r_z <= step_z;
            r_v <= step_v;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

@@ sv/aes128_gcm_engine_core.sv @@
// Top level of the AES-128-GCM engine: control sequencer, counters and result register.
// Depends on aesgcm_pkg, aesgcm_aes and aesgcm_ghash.
// An item is taken only while the engine is idle and runs to completion one at a time.
// The first item of a message first expands the key into the round key memory and then
// encrypts the zero block for the hash subkey. After that an AAD block runs the
// digit-serial GHASH multiply and its handoff, a payload block runs the AES rounds and
// then GHASH, and finish runs GHASH on the lengths and then AES on counter block 1.
// Results sit in an output register, so the next item can start while one waits.
module aes128_gcm_engine_core #(
    parameter int unsigned LENGTH_COUNT_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [aesgcm_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [63:0]                           i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  aesgcm_pkg::t_gcm_in                   i_in,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output aesgcm_pkg::t_gcm_out                  o_out
);

    logic [63:0] r_key_hi, r_key_lo, r_nonce_hi;
    logic [31:0] r_nonce_lo;
    logic        r_decrypt;

    aesgcm_pkg::t_ctl_state r_state, n_state;
    logic [1:0]   r_op;
    logic [127:0] r_data;
    logic [4:0]   r_n;
    logic         r_keys_ready, n_keys_ready;
    logic [31:0]  r_ctr, n_ctr;
    logic [LENGTH_COUNT_BITS-1:0] r_aad, n_aad, r_pay, n_pay;
    aesgcm_pkg::t_gcm_out r_res, n_res;
    aesgcm_pkg::t_gcm_out r_out;
    logic         r_out_valid;
    logic         load_out;

    aesgcm_pkg::t_aes_req aes_req;
    logic [127:0] aes_block;
    logic         aes_done;
    logic [127:0] aes_result;
    aesgcm_pkg::t_gh_ctl gh_ctl;
    logic [127:0] gh_data;
    logic         gh_done;
    logic [127:0] gh_acc;

    logic [4:0]   n_fixed;
    logic [127:0] mask;
    logic [127:0] masked_in;
    logic [127:0] pay_out;
    logic [127:0] tag;

    aesgcm_aes u_aes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (aes_req),
        .i_key    ({r_key_hi, r_key_lo}),
        .i_block  (aes_block),
        .o_done   (aes_done),
        .o_result (aes_result)
    );

    aesgcm_ghash u_ghash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (gh_ctl),
        .i_data  (gh_data),
        .o_done  (gh_done),
        .o_acc   (gh_acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi   <= '0;
            r_key_lo   <= '0;
            r_nonce_hi <= '0;
            r_nonce_lo <= '0;
            r_decrypt  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aesgcm_pkg::CFG_KEY_HIGH:     r_key_hi   <= i_cfg_data;
                aesgcm_pkg::CFG_KEY_LOW:      r_key_lo   <= i_cfg_data;
                aesgcm_pkg::CFG_NONCE_HIGH:   r_nonce_hi <= i_cfg_data;
                aesgcm_pkg::CFG_NONCE_LOW:    r_nonce_lo <= i_cfg_data[31:0];
                aesgcm_pkg::CFG_DECRYPT_MODE: r_decrypt  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign n_fixed = (i_in.valid_bytes == 5'd0 || i_in.valid_bytes > 5'd16) ?
                     5'd16 : i_in.valid_bytes;
    assign mask      = {128{1'b1}} << {5'd16 - r_n, 3'b000};
    assign masked_in = r_data & mask;
    assign pay_out   = (r_data ^ aes_result) & mask;
    assign tag       = gh_acc ^ aes_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= aesgcm_pkg::ST_IDLE;
            r_keys_ready <= 1'b0;
            r_ctr        <= 32'd2;
            r_aad        <= '0;
            r_pay        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_keys_ready <= n_keys_ready;
            r_ctr        <= n_ctr;
            r_aad        <= n_aad;
            r_pay        <= n_pay;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (r_state == aesgcm_pkg::ST_IDLE && i_in_valid) begin
            r_op   <= i_in.opcode;
            r_data <= {i_in.data_high, i_in.data_low};
            r_n    <= n_fixed;
        end
        r_res <= n_res;
        if (load_out) begin
            r_out <= r_res;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_keys_ready = r_keys_ready;
        n_ctr        = r_ctr;
        n_aad        = r_aad;
        n_pay        = r_pay;
        n_res        = r_res;
        aes_req      = '0;
        aes_block    = {r_nonce_hi, r_nonce_lo, r_ctr};
        gh_ctl       = '0;
        gh_data      = masked_in;
        load_out     = 1'b0;
        unique case (r_state)
            aesgcm_pkg::ST_IDLE: begin
                if (i_in_valid && i_in.opcode != aesgcm_pkg::OP_NONE) begin
                    if (!r_keys_ready) begin
                        aes_req.kexp = 1'b1;
                        n_state = aesgcm_pkg::ST_KEXP;
                    end else begin
                        n_state = aesgcm_pkg::ST_DISPATCH;
                    end
                end
            end
            aesgcm_pkg::ST_KEXP: begin
                if (aes_done) begin
                    aes_req.enc = 1'b1;
                    aes_block   = '0;
                    n_state     = aesgcm_pkg::ST_HENC;
                end
            end
            aesgcm_pkg::ST_HENC: begin
                if (aes_done) begin
                    gh_ctl.load_h = 1'b1;
                    gh_data       = aes_result;
                    n_keys_ready  = 1'b1;
                    n_state       = aesgcm_pkg::ST_DISPATCH;
                end
            end
            aesgcm_pkg::ST_DISPATCH: begin
                priority if (r_op == aesgcm_pkg::OP_AAD) begin
                    gh_ctl.start = 1'b1;
                    n_aad   = r_aad + LENGTH_COUNT_BITS'(r_n);
                    n_state = aesgcm_pkg::ST_AAD_HASH;
                end else if (r_op == aesgcm_pkg::OP_PAYLOAD) begin
                    aes_req.enc = 1'b1;
                    n_state     = aesgcm_pkg::ST_PAY_ENC;
                end else begin
                    gh_ctl.start = 1'b1;
                    gh_data = {64'(r_aad) << 3, 64'(r_pay) << 3};
                    n_state = aesgcm_pkg::ST_FIN_HASH;
                end
            end
            aesgcm_pkg::ST_AAD_HASH: begin
                if (gh_done) begin
                    n_state = aesgcm_pkg::ST_IDLE;
                end
            end
            aesgcm_pkg::ST_PAY_ENC: begin
                if (aes_done) begin
                    gh_ctl.start = 1'b1;
                    gh_data = r_decrypt ? masked_in : pay_out;
                    n_ctr   = r_ctr + 32'd1;
                    n_pay   = r_pay + LENGTH_COUNT_BITS'(r_n);
                    n_res.out_high  = pay_out[127:64];
                    n_res.out_low   = pay_out[63:0];
                    n_res.out_bytes = r_n;
                    n_res.is_tag    = 1'b0;
                    n_res.tag_match = 1'b0;
                    n_state = aesgcm_pkg::ST_PAY_HASH;
                end
            end
            aesgcm_pkg::ST_PAY_HASH: begin
                if (gh_done) begin
                    n_state = aesgcm_pkg::ST_EMIT;
                end
            end
            aesgcm_pkg::ST_FIN_HASH: begin
                if (gh_done) begin
                    aes_req.enc = 1'b1;
                    aes_block   = {r_nonce_hi, r_nonce_lo, 32'd1};
                    n_state     = aesgcm_pkg::ST_FIN_ENC;
                end
            end
            aesgcm_pkg::ST_FIN_ENC: begin
                if (aes_done) begin
                    n_res.out_high  = tag[127:64];
                    n_res.out_low   = tag[63:0];
                    n_res.out_bytes = 5'd16;
                    n_res.is_tag    = 1'b1;
                    n_res.tag_match = (tag == r_data);
                    gh_ctl.clear    = 1'b1;
                    n_ctr        = 32'd2;
                    n_aad        = '0;
                    n_pay        = '0;
                    n_keys_ready = 1'b0;
                    n_state      = aesgcm_pkg::ST_EMIT;
                end
            end
            aesgcm_pkg::ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    load_out = 1'b1;
                    n_state  = aesgcm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = aesgcm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != aesgcm_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ verif/aes128_gcm_engine_core_tb.sv @@
// Self-checking testbench for aes128_gcm_engine_core: AES-128-GCM messages with random
// keys, nonces, modes and block sizes, checked against a behavioral GCM predictor.
// Depends on aesgcm_pkg and the engine RTL.
module aes128_gcm_engine_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [aesgcm_pkg::CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    aesgcm_pkg::t_gcm_in i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    aesgcm_pkg::t_gcm_out o_out;

    aes128_gcm_engine_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_in(i_in), .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state.
    logic [127:0] key_reg;
    logic [63:0] nonce_hi_reg;
    logic [31:0] nonce_lo_reg;
    logic decrypt_reg;
    logic [127:0] rkeys [11];
    logic [127:0] subkey_h, ghash_acc;
    logic [31:0] ctr, aad_total, pay_total;
    logic keyed;

    aesgcm_pkg::t_gcm_out expected_q [$];
    int errors = 0;
    int got_results = 0;

    function automatic logic [7:0] mul2(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = mul2(a);
        end
        return r;
    endfunction

    function automatic logic [7:0] sbox_calc(input logic [7:0] x);
        logic [7:0] inv, v;
        inv = 8'h01;
        for (int i = 0; i < 254; i++) inv = gmul(inv, x);
        v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
            ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        return v;
    endfunction

    logic [7:0] sb [256];
    initial for (int i = 0; i < 256; i++) sb[i] = sbox_calc(i[7:0]);

    function automatic logic [7:0] bt(input logic [127:0] s, input int i);
        return s[127 - 8*i -: 8];
    endfunction

    task automatic expand_keys();
        logic [31:0] w [44];
        logic [31:0] t;
        logic [7:0] rc;
        rc = 8'h01;
        for (int k = 0; k < 4; k++) w[k] = key_reg[127 - 32*k -: 32];
        for (int k = 4; k < 44; k++) begin
            t = w[k-1];
            if (k % 4 == 0) begin
                t = {sb[t[23:16]] ^ rc, sb[t[15:8]], sb[t[7:0]], sb[t[31:24]]};
                rc = mul2(rc);
            end
            w[k] = w[k-4] ^ t;
        end
        for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endtask

    function automatic logic [127:0] encrypt_block(input logic [127:0] blk);
        logic [127:0] s;
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        s = blk ^ rkeys[0];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) t[i + 4*c] = sb[bt(s, i + 4*((c + i) % 4))];
            if (r != 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                    t[4*c]   = mul2(a0) ^ mul2(a1) ^ a1 ^ a2 ^ a3;
                    t[4*c+1] = a0 ^ mul2(a1) ^ mul2(a2) ^ a2 ^ a3;
                    t[4*c+2] = a0 ^ a1 ^ mul2(a2) ^ mul2(a3) ^ a3;
                    t[4*c+3] = mul2(a0) ^ a0 ^ a1 ^ a2 ^ mul2(a3);
                end
            end
            for (int i = 0; i < 16; i++) s[127 - 8*i -: 8] = t[i];
            s ^= rkeys[r];
        end
        return s;
    endfunction

    task automatic ghash_mix(input logic [127:0] blk);
        logic [127:0] x, z, v;
        logic lsb;
        x = ghash_acc ^ blk;
        z = 0;
        v = subkey_h;
        for (int i = 0; i < 128; i++) begin
            lsb = v[0];
            if (x[127 - i]) z ^= v;
            v = v >> 1;
            if (lsb) v[127:120] ^= 8'he1;
        end
        ghash_acc = z;
    endtask

    function automatic logic [127:0] lead_mask(input int n);
        return ~(128'h0) << (8 * (16 - n));
    endfunction

    task automatic clear_msg();
        ghash_acc = 0; ctr = 2; aad_total = 0; pay_total = 0; keyed = 0;
    endtask

    task automatic apply_config(input logic [aesgcm_pkg::CFG_IDX_BITS-1:0] idx,
                                input logic [63:0] v);
        case (idx)
            aesgcm_pkg::CFG_KEY_HIGH: key_reg[127:64] = v;
            aesgcm_pkg::CFG_KEY_LOW: key_reg[63:0] = v;
            aesgcm_pkg::CFG_NONCE_HIGH: nonce_hi_reg = v;
            aesgcm_pkg::CFG_NONCE_LOW: nonce_lo_reg = v[31:0];
            aesgcm_pkg::CFG_DECRYPT_MODE: decrypt_reg = v[0];
            default: ;
        endcase
    endtask

    // Returns 1 and fills r when the item produces a result.
    task automatic gcm_predict(input aesgcm_pkg::t_gcm_in it, output bit has,
                               output aesgcm_pkg::t_gcm_out r);
        int n;
        logic [127:0] d, m, ks, res, tag;
        has = 0;
        r = '0;
        if (it.opcode == aesgcm_pkg::OP_NONE) return;
        n = it.valid_bytes;
        if (n == 0 || n > 16) n = 16;
        if (!keyed) begin
            expand_keys();
            subkey_h = encrypt_block(128'h0);
            keyed = 1;
        end
        d = {it.data_high, it.data_low};
        m = lead_mask(n);
        if (it.opcode == aesgcm_pkg::OP_AAD) begin
            ghash_mix(d & m);
            aad_total += n;
        end else if (it.opcode == aesgcm_pkg::OP_PAYLOAD) begin
            ks = encrypt_block({nonce_hi_reg, nonce_lo_reg, ctr});
            res = (d ^ ks) & m;
            ghash_mix(decrypt_reg ? (d & m) : res);
            ctr++;
            pay_total += n;
            has = 1;
            r.out_high = res[127:64]; r.out_low = res[63:0]; r.out_bytes = n[4:0];
        end else begin
            ghash_mix({29'h0, aad_total, 3'b000, 29'h0, pay_total, 3'b000});
            tag = ghash_acc ^ encrypt_block({nonce_hi_reg, nonce_lo_reg, 32'd1});
            has = 1;
            r.out_high = tag[127:64]; r.out_low = tag[63:0]; r.out_bytes = 5'd16;
            r.is_tag = 1'b1; r.tag_match = (tag == d);
            clear_msg();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp);
        errors++;
        $display("MISMATCH result %0d %s: got %h expected %h", got_results, what, got, exp);
    endtask

    // Output side: random stall, check at rising edge.
    int stall_left = 0;
    always @(posedge i_clk) begin
        aesgcm_pkg::t_gcm_out e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", o_out.out_high, 0);
            end else begin
                e = expected_q.pop_front();
                if (o_out.out_high !== e.out_high)
                    report_mismatch("out_high", o_out.out_high, e.out_high);
                if (o_out.out_low !== e.out_low)
                    report_mismatch("out_low", o_out.out_low, e.out_low);
                if (o_out.out_bytes !== e.out_bytes)
                    report_mismatch("out_bytes", o_out.out_bytes, e.out_bytes);
                if (o_out.is_tag !== e.is_tag)
                    report_mismatch("is_tag", o_out.is_tag, e.is_tag);
                if (o_out.tag_match !== e.tag_match)
                    report_mismatch("tag_match", o_out.tag_match, e.tag_match);
            end
            got_results++;
            stall_left = $urandom_range(0, 4);
        end
    end
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(input logic [aesgcm_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [63:0] v);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        apply_config(idx, v);
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic send_item(input aesgcm_pkg::t_gcm_in it, input bit chk,
                             input aesgcm_pkg::t_gcm_out want);
        bit has;
        aesgcm_pkg::t_gcm_out r;
        int idle;
        idle = $urandom_range(0, 4);
        if (idle != 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        gcm_predict(it, has, r);
        if (has) begin
            if (chk) r = want;
            expected_q.push_back(r);
        end
        @(negedge i_clk);
    endtask

    function automatic aesgcm_pkg::t_gcm_in mk(input logic [1:0] op, input logic [63:0] h,
                                               input logic [63:0] l, input logic [4:0] n);
        aesgcm_pkg::t_gcm_in it;
        it.opcode = op; it.data_high = h; it.data_low = l; it.valid_bytes = n;
        return it;
    endfunction

    task automatic set_all(input logic [63:0] kh, input logic [63:0] kl, input logic [63:0] nh,
                           input logic [31:0] nl, input logic dm);
        write_reg(aesgcm_pkg::CFG_KEY_HIGH, kh);
        write_reg(aesgcm_pkg::CFG_KEY_LOW, kl);
        write_reg(aesgcm_pkg::CFG_NONCE_HIGH, nh);
        write_reg(aesgcm_pkg::CFG_NONCE_LOW, {32'h0, nl});
        write_reg(aesgcm_pkg::CFG_DECRYPT_MODE, {63'h0, dm});
    endtask

    function automatic logic [63:0] r64();
        return {$urandom, $urandom};
    endfunction

    typedef struct {
        aesgcm_pkg::t_gcm_in it;
        bit chk;
        aesgcm_pkg::t_gcm_out want;
    } t_row;

    initial begin
        t_row rows [$];
        aesgcm_pkg::t_gcm_out w;
        aesgcm_pkg::t_gcm_in it;
        int sent, nblk, p;
        bit has;
        logic [127:0] s_acc;
        logic [31:0] s_ctr, s_aad, s_pay;
        logic s_keyed;
        key_reg = 0; nonce_hi_reg = 0; nonce_lo_reg = 0; decrypt_reg = 0;
        subkey_h = 0;
        clear_msg();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty message with the all-zero key and nonce: the well-known test vector.
        w = '0;
        w.out_high = 64'h58e2fccefa7e3061; w.out_low = 64'h367f1d57a4e7455a;
        w.out_bytes = 5'd16; w.is_tag = 1'b1;
        rows.push_back('{mk(aesgcm_pkg::OP_FINISH, 0, 0, 0), 1, w});
        w.tag_match = 1'b1;
        rows.push_back('{mk(aesgcm_pkg::OP_FINISH, 64'h58e2fccefa7e3061,
                            64'h367f1d57a4e7455a, 5), 1, w});
        rows.push_back('{mk(aesgcm_pkg::OP_NONE, '1, '1, '1), 0, w});
        rows.push_back('{mk(aesgcm_pkg::OP_AAD, '1, '1, 16), 0, w});
        rows.push_back('{mk(aesgcm_pkg::OP_AAD, '1, '1, 1), 0, w});
        rows.push_back('{mk(aesgcm_pkg::OP_PAYLOAD, '1, '1, 16), 0, w});
        rows.push_back('{mk(aesgcm_pkg::OP_PAYLOAD, 0, 0, 0), 0, w});
        rows.push_back('{mk(aesgcm_pkg::OP_PAYLOAD, '1, '1, 31), 0, w});
        rows.push_back('{mk(aesgcm_pkg::OP_PAYLOAD, '1, '1, 8), 0, w});
        rows.push_back('{mk(aesgcm_pkg::OP_PAYLOAD, '1, '1, 9), 0, w});
        rows.push_back('{mk(aesgcm_pkg::OP_AAD, 64'h0123456789abcdef, '1, 7), 0, w});
        rows.push_back('{mk(aesgcm_pkg::OP_NONE, 0, 0, 0), 0, w});
        rows.push_back('{mk(aesgcm_pkg::OP_FINISH, '1, '1, 0), 0, w});
        foreach (rows[i]) send_item(rows[i].it, rows[i].chk, rows[i].want);
        wait_quiet();

        // Extreme settings, then a mid-message nonce, mode and key change.
        set_all('1, '1, '1, '1, 1'b1);
        send_item(mk(aesgcm_pkg::OP_PAYLOAD, 0, 0, 16), 0, w);
        send_item(mk(aesgcm_pkg::OP_FINISH, 0, 0, 16), 0, w);
        wait_quiet();
        send_item(mk(aesgcm_pkg::OP_PAYLOAD, r64(), r64(), 12), 0, w);
        wait_quiet();
        write_reg(aesgcm_pkg::CFG_NONCE_LOW, 64'h0);
        write_reg(aesgcm_pkg::CFG_DECRYPT_MODE, 64'h0);
        write_reg(aesgcm_pkg::CFG_KEY_HIGH, 64'h0);
        send_item(mk(aesgcm_pkg::OP_PAYLOAD, r64(), r64(), 16), 0, w);
        send_item(mk(aesgcm_pkg::OP_FINISH, 0, 0, 16), 0, w);
        wait_quiet();

        sent = 0;
        while (sent < 1350) begin
            wait_quiet();
            case ($urandom_range(0, 3))
                0: set_all(0, 0, 0, 0, $urandom_range(0, 1));
                1: set_all('1, '1, '1, '1, $urandom_range(0, 1));
                default: set_all(r64(), r64(), r64(), $urandom, $urandom_range(0, 1));
            endcase
            nblk = $urandom_range(0, 12);
            for (int b = 0; b < nblk; b++) begin
                p = $urandom_range(0, 19);
                it.opcode = (p < 5) ? aesgcm_pkg::OP_AAD :
                            (p < 18) ? aesgcm_pkg::OP_PAYLOAD : aesgcm_pkg::OP_NONE;
                it.data_high = r64();
                it.data_low = r64();
                it.valid_bytes = ($urandom_range(0, 3) == 0) ? 5'($urandom) :
                                 5'($urandom_range(1, 16));
                send_item(it, 0, w);
                sent++;
            end
            if ($urandom_range(0, 15) == 0) begin
                // Feed the tag that the message produces so that a match is seen.
                it = mk(aesgcm_pkg::OP_FINISH, 0, 0, 5'($urandom));
                s_acc = ghash_acc; s_ctr = ctr; s_aad = aad_total; s_pay = pay_total;
                s_keyed = keyed;
                gcm_predict(it, has, w);
                ghash_acc = s_acc; ctr = s_ctr; aad_total = s_aad; pay_total = s_pay;
                keyed = s_keyed;
                it.data_high = w.out_high;
                it.data_low = w.out_low;
            end else begin
                it = mk(aesgcm_pkg::OP_FINISH, r64(), r64(), 5'($urandom));
            end
            send_item(it, 0, w);
            sent++;
        end
        wait_quiet();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule

@@ files.f @@
sv/aesgcm_pkg.sv
sv/aesgcm_aes.sv
sv/aesgcm_ghash.sv
sv/aes128_gcm_engine_core.sv
verif/aes128_gcm_engine_core_tb.sv
